/* hdl/i2cbb_pkg.sv */
// ----------------------------------------------------------------------------
// I2C bit-bang master package
// Shared types, command codes and phase-count helpers for the sequencer.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int PHASE_W       = 5;
   localparam int LOOP_PHASES   = 3 * BITS_PER_BYTE;
   localparam logic [7:0] TIMEOUT_RESET = 8'd250;

   typedef enum logic [2:0] {
      CMD_START = 3'd0,
      CMD_STOP  = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_SEND  = 3'd3,
      CMD_READ  = 3'd4,
      CMD_WAIT  = 3'd5
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       send_ack;
      logic [8:0] sda_samples;
      logic       timeout;
   } entry_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive;
      logic       sda_level;
      logic [7:0] read_data;
      logic       ack_error;
      logic       last_phase;
   } phase_type;

   function automatic logic [PHASE_W-1:0] last_index(cmd_type c, logic timeout);
      logic [PHASE_W-1:0] r;
      case (c)
         CMD_START: r = PHASE_W'(3);
         CMD_STOP:  r = PHASE_W'(3);
         CMD_WRITE: r = PHASE_W'(LOOP_PHASES + 3);
         CMD_SEND:  r = PHASE_W'(LOOP_PHASES);
         CMD_READ:  r = PHASE_W'(2 * BITS_PER_BYTE + 4);
         CMD_WAIT:  r = timeout ? PHASE_W'(6) : PHASE_W'(3);
         default:   r = PHASE_W'(3);
      endcase
      return r;
   endfunction

endpackage

/* hdl/i2c_bit_bang_master.sv */
// ----------------------------------------------------------------------------
// I2C bit-bang master sequencer
// Turns I2C commands into a stream of SCL/SDA pin phases.
// ----------------------------------------------------------------------------
// Commands enter on the req_ queue port: an item is taken when req_push is
// high and req_full is low. Unknown command codes are taken and dropped.
// Each command yields its run of pin phases on the rsp_ queue port, one item
// per line change: start 4, stop 4, write 28, send 25, read 21, and wait-ack
// 4, or 7 on a timeout. The last item of a run carries rsp_last_phase, the
// received byte and the acknowledge error flag.
// The sequencer emits one phase per cycle while the result queue has room, and
// loads the next queued command together with the last phase of the previous
// one. When the block is idle, a taken command passes through the command
// queue and the sequencer's entry register before its first phase is queued.
// A command queue decouples the input from the sequencer and a result queue
// decouples the sequencer from the receiver. When the receiver stops popping,
// the sequencer holds, then the command queue fills and req_full rises.
// The timeout limit is written through csr_wr_en and csr_wr_data; the user must
// write it only while idle, which the block itself does not enforce. Reset empties
// both queues, sets the limit to 250 and returns both latched lines high.
// ----------------------------------------------------------------------------
module i2c_bit_bang_master
   import i2cbb_pkg::*;
#(
   parameter int CMD_QUEUE_DEPTH = 2,
   parameter int RSP_QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_send_ack,
   input  logic [8:0] req_sda_samples,
   input  logic [7:0] req_sda_high_polls,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_scl_level,
   output logic       rsp_sda_drive,
   output logic       rsp_sda_level,
   output logic [7:0] rsp_read_data,
   output logic       rsp_ack_error,
   output logic       rsp_last_phase
);

   entry_type cq_wr_data, cq_rd_data;
   logic      cq_push, cq_pop, cq_empty;
   phase_type oq_wr_data, oq_rd_data;
   logic      oq_push, oq_full;

   i2cbb_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_push           (req_push),
      .req_command        (req_command),
      .req_data_byte      (req_data_byte),
      .req_send_ack       (req_send_ack),
      .req_sda_samples    (req_sda_samples),
      .req_sda_high_polls (req_sda_high_polls),
      .queue_full         (req_full),
      .queue_push         (cq_push),
      .queue_data         (cq_wr_data)
   );

   i2cbb_fifo #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .push_data (cq_wr_data),
      .full      (req_full),
      .pop       (cq_pop),
      .pop_data  (cq_rd_data),
      .empty     (cq_empty)
   );

   i2cbb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cq_empty (cq_empty),
      .cq_data  (cq_rd_data),
      .cq_pop   (cq_pop),
      .oq_full  (oq_full),
      .oq_push  (oq_push),
      .oq_data  (oq_wr_data)
   );

   i2cbb_fifo #(
      .WIDTH ($bits(phase_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (oq_push),
      .push_data (oq_wr_data),
      .full      (oq_full),
      .pop       (rsp_pop),
      .pop_data  (oq_rd_data),
      .empty     (rsp_empty)
   );

   assign rsp_scl_level  = oq_rd_data.scl_level;
   assign rsp_sda_drive  = oq_rd_data.sda_drive;
   assign rsp_sda_level  = oq_rd_data.sda_level;
   assign rsp_read_data  = oq_rd_data.read_data;
   assign rsp_ack_error  = oq_rd_data.ack_error;
   assign rsp_last_phase = oq_rd_data.last_phase;

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_sda_drive) |-> !rsp_sda_level)
      else $error("SDA level shown while SDA is released");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last_phase) |-> (rsp_read_data == 8'd0 && !rsp_ack_error))
      else $error("Read data or error flag outside the last phase");

   assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("Queues not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      (cq_push && cq_empty) |=> !cq_empty)
      else $error("Queued command lost before the sequencer took it");

endmodule

/* hdl/i2cbb_fifo.sv */
// ----------------------------------------------------------------------------
// I2C bit-bang small queue
// Register-based first-in first-out queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
module i2cbb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/i2cbb_front.sv */
// ----------------------------------------------------------------------------
// I2C bit-bang front end
// Holds the timeout limit, drops unknown commands and resolves the wait-ack
// timeout before an item is queued for the sequencer.
// ----------------------------------------------------------------------------
module i2cbb_front
   import i2cbb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_push,
   input  logic [2:0] req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_send_ack,
   input  logic [8:0] req_sda_samples,
   input  logic [7:0] req_sda_high_polls,
   input  logic       queue_full,
   output logic       queue_push,
   output entry_type  queue_data
);

   logic [7:0] limit_ff, limit_in;
   logic       known;

   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TIMEOUT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      case (req_command)
         CMD_START, CMD_STOP, CMD_WRITE, CMD_SEND, CMD_READ, CMD_WAIT: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   assign queue_push             = req_push && !queue_full && known;
   assign queue_data.cmd         = cmd_type'(req_command);
   assign queue_data.data_byte   = req_data_byte;
   assign queue_data.send_ack    = req_send_ack;
   assign queue_data.sda_samples = req_sda_samples;
   assign queue_data.timeout     = (req_sda_high_polls > limit_ff);

endmodule

/* hdl/i2cbb_back.sv */
// ----------------------------------------------------------------------------
// I2C bit-bang back end
// Steps through the pin phases of each queued command, one phase per cycle while
// the result queue has room, and keeps the latched SCL and SDA line levels.
// ----------------------------------------------------------------------------
module i2cbb_back
   import i2cbb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      cq_empty,
   input  entry_type cq_data,
   output logic      cq_pop,
   input  logic      oq_full,
   output logic      oq_push,
   output phase_type oq_data
);

   state_type          state_ff, state_in;
   entry_type          entry_ff;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [1:0]         step_ff, step_in;
   logic [7:0]         byte_ff, byte_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;

   logic upd_scl, scl_val, upd_sda, sda_val, drv;
   logic emit, is_last, in_loop, load;

   assign is_last = (phase_ff == last_index(entry_ff.cmd, entry_ff.timeout));
   assign in_loop = ((entry_ff.cmd == CMD_WRITE) && (phase_ff < PHASE_W'(LOOP_PHASES)))
                 || ((entry_ff.cmd == CMD_SEND) && (phase_ff != '0)
                     && (phase_ff <= PHASE_W'(LOOP_PHASES)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!cq_empty) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (emit && is_last && cq_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      emit = 1'b0;
      load = 1'b0;
      case (state_ff)
         ST_IDLE: load = !cq_empty;
         ST_RUN: begin
            emit = !oq_full;
            load = !oq_full && is_last && !cq_empty;
         end
         default: begin
            emit = 1'b0;
            load = 1'b0;
         end
      endcase
   end

   assign cq_pop  = load;
   assign oq_push = emit;

   always_comb begin
      upd_scl = 1'b0;
      scl_val = 1'b0;
      upd_sda = 1'b0;
      sda_val = 1'b0;
      drv     = 1'b1;
      if (in_loop) begin
         case (step_ff)
            2'd0: begin
               upd_sda = 1'b1;
               sda_val = byte_ff[7];
            end
            2'd1: begin
               upd_scl = 1'b1;
               scl_val = 1'b1;
            end
            default: begin
               upd_scl = 1'b1;
               scl_val = 1'b0;
            end
         endcase
      end else begin
         case (entry_ff.cmd)
            CMD_START: begin
               upd_scl = phase_ff[0];
               scl_val = !phase_ff[1];
               upd_sda = !phase_ff[0];
               sda_val = !phase_ff[1];
            end
            CMD_STOP: begin
               upd_scl = !phase_ff[0];
               scl_val = phase_ff[1];
               upd_sda = phase_ff[0];
               sda_val = phase_ff[1];
            end
            CMD_WRITE: begin
               if (phase_ff == PHASE_W'(LOOP_PHASES + 3)) begin
                  upd_sda = 1'b1;
                  sda_val = 1'b1;
               end else begin
                  drv     = 1'b0;
                  upd_scl = (phase_ff != PHASE_W'(LOOP_PHASES));
                  scl_val = (phase_ff == PHASE_W'(LOOP_PHASES + 1));
               end
            end
            CMD_SEND: begin
               upd_scl = 1'b1;
               scl_val = 1'b0;
            end
            CMD_READ: begin
               if (phase_ff == '0) begin
                  drv = 1'b0;
               end else if (phase_ff <= PHASE_W'(2 * BITS_PER_BYTE + 1)) begin
                  drv     = 1'b0;
                  upd_scl = 1'b1;
                  scl_val = !phase_ff[0];
               end else if (phase_ff == PHASE_W'(2 * BITS_PER_BYTE + 2)) begin
                  upd_sda = 1'b1;
                  sda_val = !entry_ff.send_ack;
               end else begin
                  upd_scl = 1'b1;
                  scl_val = (phase_ff == PHASE_W'(2 * BITS_PER_BYTE + 3));
               end
            end
            CMD_WAIT: begin
               case (phase_ff)
                  PHASE_W'(0): begin
                     upd_sda = 1'b1;
                     sda_val = 1'b1;
                  end
                  PHASE_W'(1): begin
                     upd_scl = 1'b1;
                     scl_val = 1'b1;
                  end
                  PHASE_W'(2): drv = 1'b0;
                  PHASE_W'(3): begin
                     drv     = entry_ff.timeout;
                     upd_scl = 1'b1;
                     scl_val = 1'b0;
                  end
                  PHASE_W'(5): begin
                     upd_scl = 1'b1;
                     scl_val = 1'b1;
                  end
                  default: begin
                     upd_sda = 1'b1;
                     sda_val = (phase_ff == PHASE_W'(6));
                  end
               endcase
            end
            default: drv = 1'b1;
         endcase
      end
   end

   assign scl_in = (emit && upd_scl) ? scl_val : scl_ff;
   assign sda_in = (emit && upd_sda) ? sda_val : sda_ff;

   always_comb begin
      oq_data.scl_level  = upd_scl ? scl_val : scl_ff;
      oq_data.sda_drive  = drv;
      oq_data.sda_level  = drv && (upd_sda ? sda_val : sda_ff);
      oq_data.read_data  = '0;
      oq_data.ack_error  = 1'b0;
      oq_data.last_phase = is_last;
      if (is_last) begin
         case (entry_ff.cmd)
            CMD_READ:  oq_data.read_data = entry_ff.sda_samples[8:1];
            CMD_WRITE: oq_data.ack_error = entry_ff.sda_samples[0];
            CMD_WAIT:  oq_data.ack_error = entry_ff.timeout;
            default:   oq_data.ack_error = 1'b0;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      byte_in  = byte_ff;
      if (load) begin
         phase_in = '0;
         step_in  = '0;
         byte_in  = cq_data.data_byte;
      end else if (emit) begin
         phase_in = phase_ff + 1'b1;
         if (in_loop) begin
            step_in = (step_ff == 2'd2) ? 2'd0 : step_ff + 1'b1;
            if (step_ff == 2'd2) begin
               byte_in = {byte_ff[6:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         phase_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (load) begin
         entry_ff <= cq_data;
      end
   end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the I2C bit-bang master sequencer
// Drives command items into the request queue and checks every pin phase that
// leaves the result queue against a cycle-free model of the pin sequences,
// first with a short table of directed commands, then with random transfers
// framed by start and stop and single random commands, under several timeout limits and random stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import i2cbb_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int DRAIN_LIMIT   = 50_000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int SECTION_ITEMS = 100;
   localparam int DIRECTED_ROWS = 19;
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data;
      logic       ack;
      logic [8:0] samples;
      logic [7:0] polls;
      logic       typed;
      logic [7:0] typed_rd;
      logic       typed_err;
   } stim_row;

   logic       clock;
   logic       reset              = 1'b1;
   logic       csr_wr_en          = 1'b0;
   logic [7:0] csr_wr_data        = 8'h00;
   logic       req_push           = 1'b0;
   logic       req_full;
   logic [2:0] req_command        = CMD_START;
   logic [7:0] req_data_byte      = 8'h00;
   logic       req_send_ack       = 1'b0;
   logic [8:0] req_sda_samples    = 9'h000;
   logic [7:0] req_sda_high_polls = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop            = 1'b0;
   logic       rsp_scl_level;
   logic       rsp_sda_drive;
   logic       rsp_sda_level;
   logic [7:0] rsp_read_data;
   logic       rsp_ack_error;
   logic       rsp_last_phase;

   logic       typed_now     = 1'b0;
   logic [7:0] typed_rd_now  = 8'h00;
   logic       typed_err_now = 1'b0;
   bit         hold_request  = 1'b0;

   phase_type  pending_phases[$];
   logic       line_scl      = 1'b1;
   logic       line_sda      = 1'b1;
   logic       sda_out       = 1'b0;
   logic [7:0] timeout_limit = TIMEOUT_RESET;

   int mismatches     = 0;
   int phases_checked = 0;
   int full_cycles    = 0;
   int wait_timeouts  = 0;
   int missing_acks   = 0;
   int limit_writes   = 0;
   int cmd_count[8]   = '{default: 0};

   stim_row directed [DIRECTED_ROWS] = '{
      '{CMD_START,    8'h00, 1'b0, 9'h000, 8'd0,   1'b1, 8'h00, 1'b0},
      '{CMD_WRITE,    8'hFF, 1'b0, 9'h000, 8'd0,   1'b1, 8'h00, 1'b0},
      '{CMD_WRITE,    8'h00, 1'b0, 9'h001, 8'd0,   1'b1, 8'h00, 1'b1},
      '{CMD_WRITE,    8'hA5, 1'b1, 9'h1FE, 8'd255, 1'b1, 8'h00, 1'b0},
      '{CMD_SEND,     8'h80, 1'b0, 9'h1FF, 8'd0,   1'b0, 8'h00, 1'b0},
      '{CMD_SEND,     8'h7F, 1'b1, 9'h000, 8'd0,   1'b0, 8'h00, 1'b0},
      '{CMD_READ,     8'h00, 1'b1, 9'h1FE, 8'd0,   1'b1, 8'hFF, 1'b0},
      '{CMD_READ,     8'hFF, 1'b0, 9'h001, 8'd0,   1'b1, 8'h00, 1'b0},
      '{CMD_READ,     8'h00, 1'b1, 9'h154, 8'd0,   1'b1, 8'hAA, 1'b0},
      '{CMD_WAIT,     8'h00, 1'b0, 9'h000, 8'd0,   1'b1, 8'h00, 1'b0},
      '{CMD_WAIT,     8'h00, 1'b0, 9'h000, 8'd250, 1'b1, 8'h00, 1'b0},
      '{CMD_WAIT,     8'h00, 1'b0, 9'h000, 8'd251, 1'b1, 8'h00, 1'b1},
      '{CMD_WAIT,     8'hFF, 1'b1, 9'h1FF, 8'd255, 1'b1, 8'h00, 1'b1},
      '{CMD_SPARE_LO, 8'hFF, 1'b1, 9'h1FF, 8'd255, 1'b0, 8'h00, 1'b0},
      '{CMD_SPARE_HI, 8'h00, 1'b0, 9'h000, 8'd0,   1'b0, 8'h00, 1'b0},
      '{CMD_STOP,     8'h00, 1'b0, 9'h000, 8'd0,   1'b1, 8'h00, 1'b0},
      '{CMD_START,    8'h5A, 1'b1, 9'h0F0, 8'd17,  1'b0, 8'h00, 1'b0},
      '{CMD_WRITE,    8'h3C, 1'b0, 9'h0AB, 8'd0,   1'b1, 8'h00, 1'b1},
      '{CMD_STOP,     8'hC3, 1'b1, 9'h10F, 8'd99,  1'b0, 8'h00, 1'b0}
   };

   i2c_bit_bang_master dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_command        (req_command),
      .req_data_byte      (req_data_byte),
      .req_send_ack       (req_send_ack),
      .req_sda_samples    (req_sda_samples),
      .req_sda_high_polls (req_sda_high_polls),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_scl_level      (rsp_scl_level),
      .rsp_sda_drive      (rsp_sda_drive),
      .rsp_sda_level      (rsp_sda_level),
      .rsp_read_data      (rsp_read_data),
      .rsp_ack_error      (rsp_ack_error),
      .rsp_last_phase     (rsp_last_phase)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   task automatic emit_phase();
      pending_phases.push_back('{scl_level: line_scl, sda_drive: sda_out,
                                 sda_level: sda_out & line_sda, read_data: 8'h00,
                                 ack_error: 1'b0, last_phase: 1'b0});
   endtask

   task automatic move_scl(input logic v);
      line_scl = v;
      emit_phase();
   endtask

   task automatic move_sda(input logic v);
      sda_out  = 1'b1;
      line_sda = v;
      emit_phase();
   endtask

   task automatic float_sda();
      sda_out = 1'b0;
      emit_phase();
   endtask

   task automatic stop_condition();
      sda_out = 1'b1;
      move_scl(1'b0);
      move_sda(1'b0);
      move_scl(1'b1);
      move_sda(1'b1);
   endtask

   task automatic expand_command(input stim_row row);
      phase_type  tail;
      logic [7:0] rx;
      logic       err;
      int         i;
      rx  = 8'h00;
      err = 1'b0;
      if (row.cmd > CMD_WAIT) return;
      if (row.cmd != CMD_READ) sda_out = 1'b1;
      case (row.cmd)
         CMD_START: begin
            move_sda(1'b1);
            move_scl(1'b1);
            move_sda(1'b0);
            move_scl(1'b0);
         end
         CMD_STOP: stop_condition();
         CMD_WRITE: begin
            for (i = BITS_PER_BYTE - 1; i >= 0; i--) begin
               move_sda(row.data[i]);
               move_scl(1'b1);
               move_scl(1'b0);
            end
            float_sda();
            move_scl(1'b1);
            err = row.samples[0];
            move_scl(1'b0);
            move_sda(1'b1);
            if (err) missing_acks++;
         end
         CMD_SEND: begin
            move_scl(1'b0);
            for (i = BITS_PER_BYTE - 1; i >= 0; i--) begin
               move_sda(row.data[i]);
               move_scl(1'b1);
               move_scl(1'b0);
            end
         end
         CMD_READ: begin
            float_sda();
            for (i = 0; i < BITS_PER_BYTE; i++) begin
               move_scl(1'b0);
               move_scl(1'b1);
               rx = {rx[6:0], row.samples[BITS_PER_BYTE - i]};
            end
            move_scl(1'b0);
            move_sda(!row.ack);
            move_scl(1'b1);
            move_scl(1'b0);
         end
         CMD_WAIT: begin
            move_sda(1'b1);
            move_scl(1'b1);
            float_sda();
            if (row.polls > timeout_limit) begin
               // The slave never pulled SDA low in time, so the bus is released.
               stop_condition();
               err = 1'b1;
               wait_timeouts++;
            end else begin
               move_scl(1'b0);
            end
         end
         default: ;
      endcase
      tail            = pending_phases.pop_back();
      tail.read_data  = row.typed ? row.typed_rd : rx;
      tail.ack_error  = row.typed ? row.typed_err : err;
      tail.last_phase = 1'b1;
      pending_phases.push_back(tail);
   endtask

   always @(posedge clock) begin : accept_item
      stim_row row;
      if (reset) begin
         line_scl      = 1'b1;
         line_sda      = 1'b1;
         timeout_limit = TIMEOUT_RESET;
      end else begin
         if (csr_wr_en) timeout_limit = csr_wr_data;
         if (req_push && req_full) full_cycles++;
         if (req_push && !req_full) begin
            row = '{req_command, req_data_byte, req_send_ack, req_sda_samples,
                    req_sda_high_polls, typed_now, typed_rd_now, typed_err_now};
            cmd_count[req_command]++;
            expand_command(row);
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_phase
      phase_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_phases.size() == 0) begin
            $display("%0t: phase item with nothing expected", $time);
            mismatches++;
         end else begin
            want = pending_phases.pop_front();
            check_field("scl_level", want.scl_level, rsp_scl_level);
            check_field("sda_drive", want.sda_drive, rsp_sda_drive);
            check_field("sda_level", want.sda_level, rsp_sda_level);
            check_field("read_data", want.read_data, rsp_read_data);
            check_field("ack_error", want.ack_error, rsp_ack_error);
            check_field("last_phase", want.last_phase, rsp_last_phase);
            phases_checked++;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin : drain_results
      int run;
      int gap;
      forever begin
         if (hold_request) begin
            // Stop popping long enough for both queues to fill up.
            @(negedge clock);
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            run = $urandom_range(1, 40);
            repeat (run) begin
               @(negedge clock);
               rsp_pop = 1'b1;
            end
            gap = pick_gap();
            if (gap > 0) begin
               @(negedge clock);
               rsp_pop = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: run did not finish in time", $time);
      $display("** i2c_bit_bang_master: FAILED **");
      $finish;
   end

   task automatic send_item(input stim_row row);
      @(negedge clock);
      req_command        = row.cmd;
      req_data_byte      = row.data;
      req_send_ack       = row.ack;
      req_sda_samples    = row.samples;
      req_sda_high_polls = row.polls;
      typed_now          = row.typed;
      typed_rd_now       = row.typed_rd;
      typed_err_now      = row.typed_err;
      req_push           = 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_push = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      int waited;
      waited = 0;
      while (pending_phases.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_phases.size() != 0) begin
         $display("%0t: %0d phase items never arrived", $time, pending_phases.size());
         mismatches++;
         pending_phases.delete();
      end
   endtask

   task automatic write_limit(input logic [7:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      limit_writes++;
   endtask

   function automatic stim_row random_row(input logic [2:0] c);
      stim_row r;
      r.cmd       = c;
      r.data      = 8'($urandom_range(0, 255));
      r.ack       = 1'($urandom_range(0, 1));
      r.samples   = 9'($urandom_range(0, 511));
      r.typed     = 1'b0;
      r.typed_rd  = 8'h00;
      r.typed_err = 1'b0;
      case ($urandom_range(0, 5))
         0: r.polls = 8'd0;
         1: r.polls = timeout_limit;
         2: r.polls = (timeout_limit == 8'hFF) ? 8'hFF : timeout_limit + 8'd1;
         3: r.polls = 8'hFF;
         default: r.polls = 8'($urandom_range(0, 255));
      endcase
      return r;
   endfunction

   function automatic logic [2:0] transfer_cmd();
      case ($urandom_range(0, 3))
         0: return CMD_WRITE;
         1: return CMD_SEND;
         2: return CMD_READ;
         default: return CMD_WAIT;
      endcase
   endfunction

   initial begin : stimulus
      logic [7:0] limit_plan[4];
      logic [2:0] noise_cmd;
      int         sent;
      int         body;
      int         section;
      limit_plan = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), TIMEOUT_RESET};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[k]) begin
         send_item(directed[k]);
         idle_sender(pick_gap());
      end
      idle_sender(1);
      wait_idle();

      for (section = 0; section < 4; section++) begin
         write_limit(limit_plan[section]);
         if (section == 1) hold_request = 1'b1;
         sent = 0;
         while (sent < SECTION_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
               body = $urandom_range(1, 4);
               send_item(random_row(CMD_START));
               idle_sender(pick_gap());
               repeat (body) begin
                  send_item(random_row(transfer_cmd()));
                  idle_sender(pick_gap());
               end
               send_item(random_row(CMD_STOP));
               idle_sender(pick_gap());
               sent += body + 2;
            end else begin
               noise_cmd = 3'($urandom_range(0, 7));
               send_item(random_row(noise_cmd));
               idle_sender(pick_gap());
               if (noise_cmd <= CMD_WAIT) sent++;
            end
         end
         idle_sender(1);
         wait_idle();
      end

      $write("Checked %0d phase items: start %0d, stop %0d, write %0d, ",
             phases_checked, cmd_count[CMD_START], cmd_count[CMD_STOP],
             cmd_count[CMD_WRITE]);
      $display("send %0d, read %0d, wait %0d.",
               cmd_count[CMD_SEND], cmd_count[CMD_READ], cmd_count[CMD_WAIT]);
      $write("Unknown codes %0d, timeouts %0d, missing ACKs %0d, ",
             cmd_count[CMD_SPARE_LO] + cmd_count[CMD_SPARE_HI], wait_timeouts,
             missing_acks);
      $display("limit writes %0d, full cycles %0d.", limit_writes, full_cycles);
      if (mismatches == 0) begin
         $display("** i2c_bit_bang_master: PASSED **");
      end else begin
         $display("** i2c_bit_bang_master: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/i2cbb_pkg.sv
hdl/i2cbb_fifo.sv
hdl/i2cbb_front.sv
hdl/i2cbb_back.sv
hdl/i2c_bit_bang_master.sv
tb/tb_top.sv
